/* hdl/kdlp_pkg.sv */
// Shared types and constants for the key debounce / long press block.
package kdlp_pkg;

  // Request kinds carried on s_tuser
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_INIT   = 1'b1
  } req_t;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_TIME = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIME     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONSUME_LONG  = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] DEBOUNCE_TIME_RESET = 16'd60;
  localparam logic [15:0] HOLD_TIME_RESET     = 16'd1000;
  localparam logic        CONSUME_LONG_RESET  = 1'b1;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] hold_time;
    logic        consume_long;
  } cfg_t;

  // Per-button control flags
  typedef struct packed {
    logic raw_level;
    logic debounced_level;
    logic armed_flag;
    logic eligible_flag;
    logic long_seen;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    raw_level:       1'b0,
    debounced_level: 1'b0,
    armed_flag:      1'b1,
    eligible_flag:   1'b0,
    long_seen:       1'b0
  };

  // Result word, press_pulse in bit 0
  typedef struct packed {
    logic long_flag;
    logic stable_level;
    logic long_press_event;
    logic short_release_pulse;
    logic press_pulse;
  } result_t;

endpackage

/* hdl/key_debounce_long_press_top.sv */
// Top level of the key debounce / long press block.
// Datapath: a word accepted into the input register passes to the result register on m_tdata.
// Throughput: one word per cycle while m_tready does not stall the result; the button state updates in a single stage
// between the input register and the result register.
// Reset (rst, synchronous): empties both registers, restores the button state
// and loads the register defaults (debounce 60, hold 1000, consume on).
module key_debounce_long_press_top #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] button_level, [32:1] now_time, rest zero
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] press_pulse, [1] short_release_pulse,
                                 // [2] long_press_event, [3] stable_level,
                                 // [4] long_flag, rest zero
  input  logic                              cfg_we,
  input  logic [kdlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  kdlp_pkg::cfg_t    cfg;
  kdlp_pkg::flags_t  flags;
  kdlp_pkg::flags_t  flags_next;
  logic [TIME_WIDTH-1:0] change_stamp;
  logic [TIME_WIDTH-1:0] change_stamp_next;
  logic [TIME_WIDTH-1:0] press_stamp;
  logic [TIME_WIDTH-1:0] press_stamp_next;

  logic           in_valid;
  kdlp_pkg::req_t in_req;
  logic           in_level;
  logic [31:0]    in_now;
  logic [63:0]    now_wide;
  logic [TIME_WIDTH-1:0] now;

  logic              out_valid;
  kdlp_pkg::result_t out_data;
  kdlp_pkg::result_t result;
  logic              out_load;

  assign out_load = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | out_load;
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_data};

  // timestamps wrap at TIME_WIDTH bits
  assign now_wide = {32'd0, in_now};
  assign now      = now_wide[TIME_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= kdlp_pkg::DEBOUNCE_TIME_RESET;
      cfg.hold_time     <= kdlp_pkg::HOLD_TIME_RESET;
      cfg.consume_long  <= kdlp_pkg::CONSUME_LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kdlp_pkg::CFG_DEBOUNCE_TIME: cfg.debounce_time <= cfg_wdata;
        kdlp_pkg::CFG_HOLD_TIME:     cfg.hold_time     <= cfg_wdata;
        kdlp_pkg::CFG_CONSUME_LONG:  cfg.consume_long  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req   <= kdlp_pkg::req_t'(s_tuser);
      in_level <= s_tdata[0];
      in_now   <= s_tdata[32:1];
    end
  end

  kdlp_step #(
    .TW(TIME_WIDTH)
  ) u_step (
    .req               (in_req),
    .level             (in_level),
    .now               (now),
    .cfg               (cfg),
    .flags             (flags),
    .change_stamp      (change_stamp),
    .press_stamp       (press_stamp),
    .flags_next        (flags_next),
    .change_stamp_next (change_stamp_next),
    .press_stamp_next  (press_stamp_next),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= kdlp_pkg::FLAGS_RESET;
      change_stamp <= '0;
      press_stamp  <= '0;
    end else if (out_load) begin
      flags        <= flags_next;
      change_stamp <= change_stamp_next;
      press_stamp  <= press_stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

endmodule

/* hdl/kdlp_step.sv */
// Next-state and result logic for one button word.
module kdlp_step #(
  parameter int unsigned TW = 32
) (
  input  kdlp_pkg::req_t    req,
  input  logic              level,
  input  logic [TW-1:0]     now,
  input  kdlp_pkg::cfg_t    cfg,
  input  kdlp_pkg::flags_t  flags,
  input  logic [TW-1:0]     change_stamp,
  input  logic [TW-1:0]     press_stamp,
  output kdlp_pkg::flags_t  flags_next,
  output logic [TW-1:0]     change_stamp_next,
  output logic [TW-1:0]     press_stamp_next,
  output kdlp_pkg::result_t result
);

  logic          press_ev;
  logic          short_ev;
  logic          long_ev;
  logic [TW-1:0] since_change;
  logic [TW-1:0] since_press;

  always_comb begin
    flags_next        = flags;
    change_stamp_next = change_stamp;
    press_stamp_next  = press_stamp;
    press_ev          = 1'b0;
    short_ev          = 1'b0;
    long_ev           = 1'b0;
    since_change      = '0;
    since_press       = '0;

    unique case (req)
      kdlp_pkg::REQ_INIT: begin
        flags_next.raw_level       = level;
        flags_next.debounced_level = level;
        flags_next.armed_flag      = ~level;
        flags_next.eligible_flag   = 1'b0;
        flags_next.long_seen       = 1'b0;
        change_stamp_next          = '0;
        press_stamp_next           = '0;
      end
      kdlp_pkg::REQ_SAMPLE: begin
        if (level != flags.raw_level) begin
          flags_next.raw_level = level;
          change_stamp_next    = now;
        end
        since_change = now - change_stamp_next;
        if ((flags_next.debounced_level != flags_next.raw_level) &&
            (since_change >= TW'(cfg.debounce_time))) begin
          flags_next.debounced_level = flags_next.raw_level;
          if (flags_next.raw_level) begin
            press_stamp_next         = now;
            flags_next.long_seen     = 1'b0;
            flags_next.eligible_flag = flags.armed_flag;
            press_ev                 = flags.armed_flag;
          end else begin
            short_ev                 = flags.eligible_flag & ~flags.long_seen;
            flags_next.eligible_flag = 1'b0;
            flags_next.long_seen     = 1'b0;
            flags_next.armed_flag    = 1'b1;
          end
        end
        since_press = now - press_stamp_next;
        if (flags_next.debounced_level && flags_next.eligible_flag &&
            !flags_next.long_seen && (since_press >= TW'(cfg.hold_time))) begin
          flags_next.long_seen = 1'b1;
        end
        if (cfg.consume_long && flags_next.long_seen &&
            flags_next.debounced_level && flags_next.eligible_flag) begin
          flags_next.eligible_flag = 1'b0;
          long_ev                  = 1'b1;
        end
      end
      default: ;
    endcase

    result.press_pulse         = press_ev;
    result.short_release_pulse = short_ev;
    result.long_press_event    = long_ev;
    result.stable_level        = flags_next.debounced_level;
    result.long_flag           = flags_next.long_seen;
  end

endmodule

/* hdl/kdlp_checker.sv */
// Port-level checks for the key debounce / long press block.
module kdlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a long press is only taken while held with long_flag set
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[3] && m_tdata[4] && !m_tdata[1])
    else $error("long press event without held long press");

  // a short release leaves the button released and clears long_flag
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[3] && !m_tdata[4] && !m_tdata[0])
    else $error("short release event with button still down");

endmodule

bind key_debounce_long_press_top kdlp_checker u_kdlp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
